/* hw/rtl/bfma_pkg.sv */
// ----------------------------------------------------------------------------
// bfma_pkg
// Shared types, constants and helper functions of the bf16 FMA/ALU lane.
// ----------------------------------------------------------------------------
package bfma_pkg;

  // exponent word: holds every scaled exponent in the datapath, two's complement
  localparam int EW = 11;

  localparam logic [15:0] BF_NAN  = 16'h7fc0;
  localparam logic [15:0] BF_INF  = 16'h7f80;
  localparam logic [15:0] BF_SIGN = 16'h8000;
  localparam logic [15:0] BF_ONE  = 16'h3f80;
  localparam logic [15:0] SEL_HI  = 16'hff80;

  localparam logic signed [EW-1:0] K_OFF   = 11'sd134;
  localparam logic signed [EW-1:0] RB_OFF  = 11'sd143;
  localparam logic signed [EW-1:0] RB_ONE  = 11'sd1;
  localparam logic signed [EW-1:0] RB_OVF  = 11'sd255;
  localparam logic signed [EW-1:0] D_MAX   = 11'sd63;
  localparam logic signed [EW-1:0] SUB_MAX = 11'sd9;

  typedef enum logic [3:0] {
    OP_FMA  = 4'd0,
    OP_FMS  = 4'd1,
    OP_SEL  = 4'd4,
    OP_MIN  = 4'd5,
    OP_MAX  = 4'd7,
    OP_MUL  = 4'd10,
    OP_ADDX = 4'd11,
    OP_ADDY = 4'd12
  } op_t;

  typedef struct packed {
    logic [7:0]    mant;
    logic [EW-1:0] expo;
  } unp_t;

  // stage 1: classified operands and raw product
  typedef struct packed {
    logic          valid;
    logic          bypass;
    logic [15:0]   bypass_val;
    logic          psign;
    logic          csign;
    logic          czero;
    logic [15:0]   pm;
    logic [EW-1:0] pk;
    logic [7:0]    cm;
    logic [EW-1:0] ck;
  } s1_t;

  // stage 2: aligned addends, lsb weight 2^(ak-20)
  typedef struct packed {
    logic          valid;
    logic          bypass;
    logic [15:0]   bypass_val;
    logic          asg;
    logic          bsg;
    logic [35:0]   am;
    logic [35:0]   bm;
    logic [EW-1:0] ak;
  } s2_t;

  // stage 3: magnitude of the sum
  typedef struct packed {
    logic          valid;
    logic          bypass;
    logic [15:0]   bypass_val;
    logic          rsign;
    logic [36:0]   sum;
    logic [EW-1:0] ak;
  } s3_t;

  // stage 4: normalized sum, biased exponent before rounding
  typedef struct packed {
    logic          valid;
    logic          bypass;
    logic [15:0]   bypass_val;
    logic          rsign;
    logic [36:0]   ns;
    logic [EW-1:0] rb;
  } s4_t;

  function automatic logic is_nan(input logic [15:0] v);
    return v[14:0] > BF_INF[14:0];
  endfunction

  function automatic logic is_inf(input logic [15:0] v);
    return v[14:0] == BF_INF[14:0];
  endfunction

  function automatic logic is_zero(input logic [15:0] v);
    return v[14:0] == 15'd0;
  endfunction

  function automatic logic [15:0] order_key(input logic [15:0] v);
    return v[15] ? ~v : (v | BF_SIGN);
  endfunction

  // finite nonzero value = mant * 2^expo, mant in [128,255]
  function automatic unp_t unpack(input logic [15:0] v);
    logic [7:0] m;
    logic [7:0] ef;
    logic [3:0] lz;
    logic signed [EW-1:0] eb;
    unp_t r;
    ef = (v[14:7] == 8'd0) ? 8'd1 : v[14:7];
    m  = {v[14:7] != 8'd0, v[6:0]};
    lz = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (m[i]) lz = 4'(7 - i);
    end
    eb = $signed({3'b000, ef});
    r.mant = m << lz;
    r.expo = eb - K_OFF - $signed({7'd0, lz});
    return r;
  endfunction

  function automatic logic [5:0] lzc37(input logic [36:0] s);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 37; i++) begin
      if (s[i]) n = 6'(36 - i);
    end
    return n;
  endfunction

endpackage

/* hw/rtl/bfma_decode.sv */
// ----------------------------------------------------------------------------
// bfma_decode
// Operand selection, special-case results, unpacking and 8x8 product.
// ----------------------------------------------------------------------------
module bfma_decode import bfma_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [3:0]  opcode,
  input  logic [15:0] x_operand,
  input  logic [15:0] y_operand,
  input  logic [15:0] z_accum,
  output s1_t         s1
);

  logic [15:0] a, b, c;
  logic        fused;
  logic [15:0] plain;
  logic        psign, pinf;
  unp_t        ua, ub, uc;
  s1_t         s1_next;

  always_comb begin
    a     = x_operand;
    b     = y_operand;
    c     = z_accum;
    fused = 1'b1;
    plain = z_accum;
    case (op_t'(opcode))
      OP_FMA:  ;
      OP_FMS:  a = x_operand ^ BF_SIGN;
      OP_MUL:  c = BF_SIGN;
      OP_ADDX: b = BF_ONE;
      OP_ADDY: a = BF_ONE;
      OP_SEL: begin
        fused = 1'b0;
        plain = (x_operand == 16'd0 || (x_operand >= BF_SIGN && x_operand <= SEL_HI))
                ? 16'd0 : y_operand;
      end
      OP_MIN: begin
        fused = 1'b0;
        if (is_nan(x_operand) || is_nan(z_accum)) plain = BF_NAN;
        else plain = (order_key(x_operand) < order_key(z_accum)) ? x_operand : z_accum;
      end
      OP_MAX: begin
        fused = 1'b0;
        if (is_nan(x_operand) || is_nan(z_accum)) plain = BF_NAN;
        else plain = (order_key(x_operand) > order_key(z_accum)) ? x_operand : z_accum;
      end
      default: fused = 1'b0;
    endcase
  end

  always_comb begin
    psign = a[15] ^ b[15];
    pinf  = is_inf(a) || is_inf(b);
    ua    = unpack(a);
    ub    = unpack(b);
    uc    = unpack(c);

    s1_next.valid      = in_valid;
    s1_next.bypass     = 1'b1;
    s1_next.bypass_val = plain;
    if (fused) begin
      if (is_nan(a) || is_nan(b) || is_nan(c)) s1_next.bypass_val = BF_NAN;
      else if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a)))
        s1_next.bypass_val = BF_NAN;
      else if (is_inf(c) && pinf && (c[15] != psign)) s1_next.bypass_val = BF_NAN;
      else if (is_inf(c)) s1_next.bypass_val = c;
      else if (pinf) s1_next.bypass_val = {psign, BF_INF[14:0]};
      else if (is_zero(a) || is_zero(b))
        s1_next.bypass_val = is_zero(c) ? (c & {psign, 15'd0}) : c;
      else s1_next.bypass = 1'b0;
    end
    s1_next.psign = psign;
    s1_next.csign = c[15];
    s1_next.czero = is_zero(c);
    s1_next.pm    = {8'd0, ua.mant} * {8'd0, ub.mant};
    s1_next.pk    = $signed(ua.expo) + $signed(ub.expo);
    s1_next.cm    = is_zero(c) ? 8'd0 : uc.mant;
    s1_next.ck    = $signed(uc.expo) - 11'sd8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (en) begin
      s1 <= s1_next;
    end
  end

endmodule

/* hw/rtl/bfma_align.sv */
// ----------------------------------------------------------------------------
// bfma_align
// Exponent compare and right shift of the smaller addend with sticky.
// ----------------------------------------------------------------------------
module bfma_align import bfma_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  s1_t  s1,
  output s2_t  s2
);

  logic [35:0]          pa, ca, bpre;
  logic signed [EW-1:0] pk, ck, d;
  logic [5:0]           dc;
  logic [71:0]          sh;
  s2_t                  s2_next;

  always_comb begin
    pa = {s1.pm, 20'd0};
    ca = {s1.cm, 28'd0};
    pk = $signed(s1.pk);
    ck = $signed(s1.ck);

    s2_next.valid      = s1.valid;
    s2_next.bypass     = s1.bypass;
    s2_next.bypass_val = s1.bypass_val;
    if (s1.czero || pk >= ck) begin
      s2_next.am  = pa;
      s2_next.asg = s1.psign;
      s2_next.ak  = s1.pk;
      s2_next.bsg = s1.csign;
      bpre        = ca;
      d           = s1.czero ? 11'sd0 : (pk - ck);
    end else begin
      s2_next.am  = ca;
      s2_next.asg = s1.csign;
      s2_next.ak  = s1.ck;
      s2_next.bsg = s1.psign;
      bpre        = pa;
      d           = ck - pk;
    end
    dc = (d > D_MAX) ? 6'd63 : d[5:0];
    sh = {bpre, 36'd0} >> dc;
    // fold shifted-out bits into the lsb
    s2_next.bm = {sh[71:37], sh[36] | (|sh[35:0])};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (en) begin
      s2 <= s2_next;
    end
  end

endmodule

/* hw/rtl/bfma_addnorm.sv */
// ----------------------------------------------------------------------------
// bfma_addnorm
// Signed-magnitude add of the aligned addends, then leading-zero normalize.
// ----------------------------------------------------------------------------
module bfma_addnorm import bfma_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  s2_t  s2,
  output s3_t  s3,
  output s4_t  s4
);

  logic [36:0] ea, eb;
  logic [5:0]  lz;
  s3_t         s3_next;
  s4_t         s4_next;

  always_comb begin
    ea = {1'b0, s2.am};
    eb = {1'b0, s2.bm};
    s3_next.valid      = s2.valid;
    s3_next.bypass     = s2.bypass;
    s3_next.bypass_val = s2.bypass_val;
    s3_next.ak         = s2.ak;
    s3_next.rsign      = s2.asg;
    if (s2.asg == s2.bsg) begin
      s3_next.sum = ea + eb;
    end else if (ea >= eb) begin
      s3_next.sum = ea - eb;
    end else begin
      s3_next.sum   = eb - ea;
      s3_next.rsign = s2.bsg;
    end
    // exact cancellation gives +0
    if (!s2.bypass && s3_next.sum == 37'd0) begin
      s3_next.bypass     = 1'b1;
      s3_next.bypass_val = 16'd0;
    end
  end

  always_comb begin
    lz = lzc37(s3.sum);
    s4_next.valid      = s3.valid;
    s4_next.bypass     = s3.bypass;
    s4_next.bypass_val = s3.bypass_val;
    s4_next.rsign      = s3.rsign;
    s4_next.ns         = s3.sum << lz;
    s4_next.rb         = $signed(s3.ak) + RB_OFF - $signed({5'd0, lz});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3.valid <= 1'b0;
      s4.valid <= 1'b0;
    end else if (en) begin
      s3 <= s3_next;
      s4 <= s4_next;
    end
  end

endmodule

/* hw/rtl/bfma_round.sv */
// ----------------------------------------------------------------------------
// bfma_round
// Subnormal shift, round-half-even, overflow to infinity, output register.
// ----------------------------------------------------------------------------
module bfma_round import bfma_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  s4_t         s4,
  output logic        out_valid,
  output logic [15:0] result
);

  logic signed [EW-1:0] rb, t;
  logic [3:0]           rsh;
  logic [45:0]          ext;
  logic [36:0]          sh;
  logic                 lost, g, st, rup;
  logic [7:0]           kept, e8;
  logic [14:0]          mag;
  logic [15:0]          result_next;

  always_comb begin
    rb  = $signed(s4.rb);
    t   = RB_ONE - rb;
    if (rb >= RB_ONE) rsh = 4'd0;
    else if (t > SUB_MAX) rsh = 4'd9;
    else rsh = t[3:0];
    ext  = {s4.ns, 9'd0} >> rsh;
    sh   = ext[45:9];
    lost = |ext[8:0];
    kept = sh[36:29];
    g    = sh[28];
    st   = (|sh[27:0]) | lost;
    rup  = g & (st | kept[0]);
    e8   = (rb >= RB_ONE) ? (rb[7:0] - 8'd1) : 8'd0;
    mag  = {e8, 7'd0} + {7'd0, kept} + {14'd0, rup};
    if (rb >= RB_OVF) mag = BF_INF[14:0];
    result_next = s4.bypass ? s4.bypass_val : {s4.rsign, mag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s4.valid;
      result    <= result_next;
    end
  end

endmodule

/* hw/rtl/bf16_fma_alu_top.sv */
// ----------------------------------------------------------------------------
// bf16_fma_alu_top
// One bfloat16 lane: fused multiply-add, select, min/max, add.
//
//   channel | signals                                         | dir
//   input   | in_valid, in_ready, opcode, x_operand,          | in
//           | y_operand, z_accum                              |
//   output  | out_valid, out_ready, result                    | out
//
// Five register stages: decode/multiply, align, add, normalize, round.
// One transaction enters per cycle while in_ready is high.
// The whole pipe advances together; it holds only when the output register
// is full and out_ready is low, so nothing is dropped or repeated.
// Reset clears the stage valid bits.
// ----------------------------------------------------------------------------
module bf16_fma_alu_top import bfma_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  opcode,
  input  logic [15:0] x_operand,
  input  logic [15:0] y_operand,
  input  logic [15:0] z_accum,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] result
);

  logic en;
  s1_t  s1;
  s2_t  s2;
  s3_t  s3;
  s4_t  s4;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  bfma_decode u_decode (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid), .opcode(opcode),
    .x_operand(x_operand), .y_operand(y_operand), .z_accum(z_accum), .s1(s1)
  );

  bfma_align u_align (.clk(clk), .rst(rst), .en(en), .s1(s1), .s2(s2));

  bfma_addnorm u_addnorm (.clk(clk), .rst(rst), .en(en), .s2(s2), .s3(s3), .s4(s4));

  bfma_round u_round (
    .clk(clk), .rst(rst), .en(en), .s4(s4), .out_valid(out_valid), .result(result)
  );

`ifndef SYNTH
  a_rst_clear: assert property (@(posedge clk) rst |=> !out_valid && !s1.valid)
    else $error("valid bits not cleared by reset");
  a_advance: assert property (@(posedge clk) disable iff (rst)
    en |=> s2.valid == $past(s1.valid) && out_valid == $past(s4.valid))
    else $error("stage valid lost or duplicated on advance");
  a_sum_nonzero: assert property (@(posedge clk) disable iff (rst)
    s3.valid && !s3.bypass |-> s3.sum != 37'd0)
    else $error("zero sum reached rounding path");
  a_normalized: assert property (@(posedge clk) disable iff (rst)
    s4.valid && !s4.bypass |-> s4.ns[36])
    else $error("sum not normalized");
`endif

endmodule
